[sv/assert_macros.svh]
// Assertion macros used by the checker file of the pedal conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pac_pkg.sv]
// Shared widths, reset values and inter-module types of the pedal conditioner.
package pac_pkg;

  // Port and field widths.
  localparam int unsigned PEDAL_W    = 2;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned AXIS_W     = 12;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned SETUP_W    = 49;
  localparam int unsigned CURVE_W    = 48;
  localparam int unsigned LEVEL_W    = 32;

  // Divider datapath: remainder holds any divisor, quotient register is one word.
  localparam int unsigned DIV_REM_W  = 12;
  localparam int unsigned DIV_Q_W    = 32;
  localparam int unsigned DIV_CNT_W  = 4;

  // Count loaded into the divider at start: two quotient bits are produced per cycle.
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_FRAC = 4'd7;   // 16 quotient bits
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_WORD = 4'd15;  // 32 quotient bits

  // Fixed-point constants.
  localparam int unsigned FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
  localparam int unsigned Y_W = 23;
  localparam logic [Y_W-1:0]    Y_FULL    = 23'd6553600;  // 100 percent in Q16
  localparam logic [DIV_REM_W-1:0] PCT_DEN = 12'd100;
  localparam logic [6:0]        ALPHA_MAX = 7'd95;
  localparam logic [6:0]        PCT_ALL   = 7'd100;

  // Register reset values.
  localparam logic [SETUP_W-1:0] SETUP_RESET = 49'h0_C800_00FF_F000;
  localparam logic [CURVE_W-1:0] CURVE_RESET = 48'h6450_3C28_1400;

  // Decoded settings of the pedal being conditioned.
  typedef struct packed {
    logic [7:0]          dz_high;
    logic [7:0]          dz_low;
    logic [7:0]          smooth;
    logic                invert;
    logic [11:0]         range_max;
    logic [11:0]         range_min;
    logic [CURVE_W-1:0]  curve;
  } pedal_cfg_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  hi;
    logic [DIV_Q_W-1:0]    lo;
    logic [DIV_REM_W-1:0]  den;
    logic [DIV_CNT_W-1:0]  last_step;
  } div_req_t;

  // Answer from the shared divider.
  typedef struct packed {
    logic                done;
    logic [DIV_Q_W-1:0]  quot;
  } div_rsp_t;

endpackage

[sv/pac_regs.sv]
// Per-pedal setup and curve registers behind the APB-style configuration port.
module pac_regs #(
  parameter int unsigned NUM_PEDALS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pac_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pac_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  input  logic [pac_pkg::PEDAL_W-1:0]   sel_pedal,
  output pac_pkg::pedal_cfg_t           sel_cfg
);
  import pac_pkg::*;

  localparam int unsigned IDX_W = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;

  typedef enum logic [2:0] {
    REG_P0_SETUP,
    REG_P0_CURVE,
    REG_P1_SETUP,
    REG_P1_CURVE,
    REG_P2_SETUP,
    REG_P2_CURVE
  } reg_idx_t;

  logic [SETUP_W-1:0] setup_r [NUM_PEDALS];
  logic [CURVE_W-1:0] curve_r [NUM_PEDALS];

  reg_idx_t           reg_idx;
  logic [PEDAL_W-1:0] addr_pedal;
  logic               addr_ok;
  logic               wr_en;
  logic [SETUP_W-1:0] sel_setup;
  logic [CURVE_W-1:0] sel_curve;

  // Registers sit eight bytes apart; setup and curve of one pedal are neighbours.
  assign reg_idx    = reg_idx_t'(paddr[5:3]);
  assign addr_pedal = paddr[5:4];
  assign addr_ok    = 32'(addr_pedal) < NUM_PEDALS;
  assign wr_en      = psel && penable && pwrite && addr_ok;
  assign pready     = 1'b1;

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PEDALS; k++) begin
        setup_r[k] <= SETUP_RESET;
        curve_r[k] <= CURVE_RESET;
      end
    end else if (wr_en) begin
      unique case (reg_idx) inside
        REG_P0_SETUP, REG_P1_SETUP, REG_P2_SETUP: begin
          setup_r[addr_pedal[IDX_W-1:0]] <= pwdata[SETUP_W-1:0];
        end
        REG_P0_CURVE, REG_P1_CURVE, REG_P2_CURVE: begin
          curve_r[addr_pedal[IDX_W-1:0]] <= pwdata[CURVE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    prdata = '0;
    if (addr_ok) begin
      unique case (reg_idx) inside
        REG_P0_SETUP, REG_P1_SETUP, REG_P2_SETUP: begin
          prdata = CFG_DATA_W'(setup_r[addr_pedal[IDX_W-1:0]]);
        end
        REG_P0_CURVE, REG_P1_CURVE, REG_P2_CURVE: begin
          prdata = CFG_DATA_W'(curve_r[addr_pedal[IDX_W-1:0]]);
        end
        default: begin
          prdata = '0;
        end
      endcase
    end
  end

  // Settings of the pedal the sequencer is working on, split into fields.
  always_comb begin
    sel_setup = SETUP_RESET;
    sel_curve = CURVE_RESET;
    if (32'(sel_pedal) < NUM_PEDALS) begin
      sel_setup = setup_r[sel_pedal[IDX_W-1:0]];
      sel_curve = curve_r[sel_pedal[IDX_W-1:0]];
    end
    sel_cfg.range_min = sel_setup[11:0];
    sel_cfg.range_max = sel_setup[23:12];
    sel_cfg.invert    = sel_setup[24];
    sel_cfg.smooth    = sel_setup[32:25];
    sel_cfg.dz_low    = sel_setup[40:33];
    sel_cfg.dz_high   = sel_setup[48:41];
    sel_cfg.curve     = sel_curve;
  end

endmodule

[sv/pac_div.sv]
// Shared restoring divider producing two quotient bits per cycle.
module pac_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pac_pkg::div_req_t req,
  output pac_pkg::div_rsp_t rsp
);
  import pac_pkg::*;

  localparam int unsigned STEPS_PER_CYCLE = 2;

  logic [DIV_REM_W-1:0] rem_r;
  logic [DIV_REM_W-1:0] rem_nxt;
  logic [DIV_Q_W-1:0]   quo_r;
  logic [DIV_Q_W-1:0]   quo_nxt;
  logic [DIV_REM_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Two dependent compare-and-subtract steps; the dividend shifts out of the
  // top of the quotient register while quotient bits shift in at the bottom.
  // The caller guarantees that the starting remainder is below the divisor.
  always_comb begin
    logic [DIV_REM_W:0] trial;
    logic               qbit;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
      trial = {rem_nxt, quo_nxt[DIV_Q_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_REM_W'(trial - {1'b0, den_r});
        qbit    = 1'b1;
      end else begin
        rem_nxt = trial[DIV_REM_W-1:0];
        qbit    = 1'b0;
      end
      quo_nxt = {quo_nxt[DIV_Q_W-2:0], qbit};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.last_step;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.hi;
      quo_r <= req.lo;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

[sv/pac_core.sv]
// Sequencer, shared multiplier and smoothing state of the pedal conditioner.
module pac_core #(
  parameter int unsigned NUM_PEDALS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pac_pkg::PEDAL_W-1:0]   in_pedal,
  input  logic [pac_pkg::SAMPLE_W-1:0]  in_raw_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pac_pkg::PEDAL_W-1:0]   out_pedal_echo,
  output logic [pac_pkg::VALUE_W-1:0]   out_conditioned_value,
  output logic [pac_pkg::AXIS_W-1:0]    out_axis_value,
  output logic [pac_pkg::PEDAL_W-1:0]   sel_pedal,
  input  pac_pkg::pedal_cfg_t           cfg,
  output pac_pkg::div_req_t             div_req,
  input  pac_pkg::div_rsp_t             div_rsp
);
  import pac_pkg::*;

  localparam int unsigned IDX_W  = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;
  localparam int unsigned PROD_W = 42;
  localparam int unsigned SUM_W  = 39;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_NDIV,
    S_INV,
    S_DZ,
    S_DZDIV,
    S_CURVE,
    S_CURVE2,
    S_TGT,
    S_TDIV,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_LDIV,
    S_OUT
  } state_t;

  // Curve point j of a packed curve register; points past the last read as zero.
  function automatic logic [7:0] curve_point(input logic [CURVE_W-1:0] c,
                                             input logic [2:0] j);
    logic [7:0] pt;
    pt = '0;
    if (j < 3'd6) begin
      pt = c[{j, 3'b000} +: 8];
    end
    return pt;
  endfunction

  state_t               state_r, state_nxt;
  logic [PEDAL_W-1:0]   pedal_r, pedal_nxt;
  logic [SAMPLE_W-1:0]  raw_r, raw_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [7:0]           base_r, base_nxt;
  logic [Y_W-1:0]       y_r, y_nxt;
  logic [LEVEL_W-1:0]   tgt_r, tgt_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [VALUE_W-1:0]   res_r, res_nxt;
  logic [LEVEL_W-1:0]   level_r [NUM_PEDALS];
  logic                 out_valid_r;
  logic [PEDAL_W-1:0]   out_pedal_r;
  logic [VALUE_W-1:0]   out_value_r;

  logic                 pedal_ok;
  logic [IDX_W-1:0]     pidx;
  logic [LEVEL_W-1:0]   level_rd;
  logic                 level_we;
  logic                 out_load;
  logic [SAMPLE_W-1:0]  span;
  logic [SAMPLE_W-1:0]  excess;
  logic [7:0]           dz_span;
  logic [Y_W-1:0]       n100;
  logic [Y_W:0]         dz_off;
  logic [Y_W-1:0]       dz_num;
  logic [18:0]          seg_pos;
  logic [2:0]           seg;
  logic [15:0]          seg_frac;
  logic [7:0]           p_lo;
  logic [7:0]           p_hi;
  logic signed [25:0]   ysum;
  logic [SUM_W-1:0]     ymul;
  logic [6:0]           alpha;
  logic [6:0]           beta;
  logic [SUM_W-1:0]     smooth_sum;
  logic [LEVEL_W:0]     rounded;
  logic signed [32:0]   mul_a;
  logic signed [8:0]    mul_b;

  assign pedal_ok = 32'(pedal_r) < NUM_PEDALS;
  assign pidx     = pedal_r[IDX_W-1:0];
  assign level_rd = pedal_ok ? level_r[pidx] : '0;
  assign sel_pedal = pedal_r;

  // Range normalisation operands; a sample at or below the minimum gives zero excess.
  assign span   = cfg.range_max - cfg.range_min;
  assign excess = (raw_r > cfg.range_min) ? raw_r - cfg.range_min : '0;

  // Deadzone numerator: n*100 - dz_low*65536, floored at zero.
  assign dz_span = cfg.dz_high - cfg.dz_low;
  assign n100    = Y_W'({frac_r, 6'b0}) + Y_W'({frac_r, 5'b0}) + Y_W'({frac_r, 2'b0});
  assign dz_off  = {cfg.dz_low, 16'h0000};
  assign dz_num  = ({1'b0, n100} > dz_off) ? Y_W'({1'b0, n100} - dz_off) : '0;

  // Curve segment and position within it: s = 5n.
  assign seg_pos  = 19'({frac_r, 2'b00}) + 19'(frac_r);
  assign seg      = seg_pos[18:16];
  assign seg_frac = seg_pos[15:0];
  assign p_lo     = curve_point(cfg.curve, seg);
  assign p_hi     = curve_point(cfg.curve, seg + 3'd1);
  assign ysum     = $signed({2'b00, base_r, 16'h0000}) + $signed(prod_r[25:0]);

  // y * 65535 as a shift and subtract.
  assign ymul = {y_r, 16'h0000} - SUM_W'(y_r);

  // Smoothing weights and the rounded weighted sum.
  assign alpha      = (cfg.smooth > 8'(ALPHA_MAX)) ? ALPHA_MAX : cfg.smooth[6:0];
  assign beta       = PCT_ALL - alpha;
  assign smooth_sum = acc_r + prod_r[SUM_W-1:0] + SUM_W'(50);
  assign rounded    = {1'b0, div_rsp.quot} + (LEVEL_W+1)'(32768);

  // Shared multiplier, registered before any use of its product.
  assign prod_nxt = mul_a * mul_b;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Sequencer next-state and datapath selection.
  always_comb begin
    state_nxt = state_r;
    pedal_nxt = pedal_r;
    raw_nxt   = raw_r;
    frac_nxt  = frac_r;
    base_nxt  = base_r;
    y_nxt     = y_r;
    tgt_nxt   = tgt_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    level_we  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pedal_nxt = in_pedal;
          raw_nxt   = in_raw_sample;
          state_nxt = S_NORM;
        end
      end

      // Normalise against the calibrated range; an empty range gives zero, an unknown pedal a zero result.
      S_NORM: begin
        if (!pedal_ok) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else if (cfg.range_max > cfg.range_min) begin
          if (excess >= span) begin
            frac_nxt  = FRAC_ONE;
            state_nxt = S_INV;
          end else begin
            div_req.start     = 1'b1;
            div_req.hi        = excess;
            div_req.lo        = '0;
            div_req.den       = span;
            div_req.last_step = DIV_LAST_FRAC;
            state_nxt         = S_NDIV;
          end
        end else begin
          frac_nxt  = '0;
          state_nxt = S_INV;
        end
      end

      S_NDIV: begin
        if (div_rsp.done) begin
          frac_nxt  = {1'b0, div_rsp.quot[15:0]};
          state_nxt = S_INV;
        end
      end

      S_INV: begin
        if (cfg.invert) begin
          frac_nxt = FRAC_ONE - frac_r;
        end
        state_nxt = S_DZ;
      end

      // Deadzone rescale; an empty deadzone gives zero.
      S_DZ: begin
        if (cfg.dz_high > cfg.dz_low) begin
          if ({1'b0, dz_num[22:16]} >= dz_span) begin
            frac_nxt  = FRAC_ONE;
            state_nxt = S_CURVE;
          end else begin
            div_req.start     = 1'b1;
            div_req.hi        = DIV_REM_W'(dz_num[22:16]);
            div_req.lo        = {dz_num[15:0], 16'h0000};
            div_req.den       = DIV_REM_W'(dz_span);
            div_req.last_step = DIV_LAST_FRAC;
            state_nxt         = S_DZDIV;
          end
        end else begin
          frac_nxt  = '0;
          state_nxt = S_CURVE;
        end
      end

      S_DZDIV: begin
        if (div_rsp.done) begin
          frac_nxt  = {1'b0, div_rsp.quot[15:0]};
          state_nxt = S_CURVE;
        end
      end

      // Segment slope times position; at full travel the position is zero.
      S_CURVE: begin
        mul_a     = $signed(33'(seg_frac));
        mul_b     = $signed(9'(p_hi) - 9'(p_lo));
        base_nxt  = p_lo;
        state_nxt = S_CURVE2;
      end

      S_CURVE2: begin
        if (ysum[25]) begin
          y_nxt = '0;
        end else if (ysum > $signed(26'(Y_FULL))) begin
          y_nxt = Y_FULL;
        end else begin
          y_nxt = ysum[Y_W-1:0];
        end
        state_nxt = S_TGT;
      end

      // Target level: y * 65535 / 100.
      S_TGT: begin
        div_req.start     = 1'b1;
        div_req.hi        = DIV_REM_W'(ymul[SUM_W-1:32]);
        div_req.lo        = ymul[31:0];
        div_req.den       = PCT_DEN;
        div_req.last_step = DIV_LAST_WORD;
        state_nxt         = S_TDIV;
      end

      S_TDIV: begin
        if (div_rsp.done) begin
          tgt_nxt   = div_rsp.quot;
          state_nxt = S_MUL1;
        end
      end

      S_MUL1: begin
        mul_a     = $signed({1'b0, level_rd});
        mul_b     = $signed({2'b00, alpha});
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        acc_nxt   = prod_r[SUM_W-1:0];
        mul_a     = $signed({1'b0, tgt_r});
        mul_b     = $signed({2'b00, beta});
        state_nxt = S_SUM;
      end

      // Weighted sum plus one half, divided by 100.
      S_SUM: begin
        div_req.start     = 1'b1;
        div_req.hi        = DIV_REM_W'(smooth_sum[SUM_W-1:32]);
        div_req.lo        = smooth_sum[31:0];
        div_req.den       = PCT_DEN;
        div_req.last_step = DIV_LAST_WORD;
        state_nxt         = S_LDIV;
      end

      S_LDIV: begin
        if (div_rsp.done) begin
          level_we  = 1'b1;
          res_nxt   = rounded[LEVEL_W] ? '1 : rounded[LEVEL_W-1:16];
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, smoothing levels and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_PEDALS; k++) begin
        level_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (level_we) begin
        level_r[pidx] <= div_rsp.quot;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    pedal_r <= pedal_nxt;
    raw_r   <= raw_nxt;
    frac_r  <= frac_nxt;
    base_r  <= base_nxt;
    y_r     <= y_nxt;
    tgt_r   <= tgt_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_pedal_r <= pedal_r;
      out_value_r <= res_r;
    end
  end

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_pedal_echo        = out_pedal_r;
  assign out_conditioned_value = out_value_r;
  assign out_axis_value        = out_value_r[VALUE_W-1:VALUE_W-AXIS_W];

endmodule

[sv/pedal_axis_conditioner_unit.sv]
// Top level of the pedal axis conditioner: configuration registers, sequencer and divider.
//
// Each transferred sample is normalised against its pedal's calibrated range, optionally
// inverted, passed through a percent deadzone and a six-point percent curve, scaled to
// 16 bits and smoothed with a per-pedal Q16.16 level. One sample is processed at a time:
// the next sample is taken only once the result of the last is in the output register,
// and a range or deadzone division is skipped when its result would saturate. A sample
// whose pedal index is not below NUM_PEDALS yields a zero result without touching any
// smoothing level. Divisions go to the single shared divider, which delivers two quotient
// bits per cycle: two 16-bit divisions (range and deadzone) and two 32-bit divisions by
// 100 (target level and smoothing). A finished result waits in the output register while
// the next sample is taken. Configuration writes take effect at once and may be read
// back.
module pedal_axis_conditioner_unit #(
  parameter int unsigned NUM_PEDALS = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pac_pkg::PEDAL_W-1:0]    in_pedal,
  input  logic [pac_pkg::SAMPLE_W-1:0]   in_raw_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pac_pkg::PEDAL_W-1:0]    out_pedal_echo,
  output logic [pac_pkg::VALUE_W-1:0]    out_conditioned_value,
  output logic [pac_pkg::AXIS_W-1:0]     out_axis_value,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pac_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pac_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pac_pkg::*;

  logic [PEDAL_W-1:0] sel_pedal;
  pedal_cfg_t         sel_cfg;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Configuration registers.
  pac_regs #(
    .NUM_PEDALS(NUM_PEDALS)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sel_pedal(sel_pedal),
    .sel_cfg  (sel_cfg)
  );

  // Shared divider.
  pac_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Sequencer with multiplier and smoothing state.
  pac_core #(
    .NUM_PEDALS(NUM_PEDALS)
  ) u_core (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_pedal             (in_pedal),
    .in_raw_sample        (in_raw_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pedal_echo       (out_pedal_echo),
    .out_conditioned_value(out_conditioned_value),
    .out_axis_value       (out_axis_value),
    .sel_pedal            (sel_pedal),
    .cfg                  (sel_cfg),
    .div_req              (div_req),
    .div_rsp              (div_rsp)
  );

endmodule

[sv/pac_checker.sv]
// Port-level checks of the pedal conditioner and their bind to the top level.
`include "assert_macros.svh"

module pac_checker #(
  parameter int unsigned NUM_PEDALS = 3
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pac_pkg::PEDAL_W-1:0]  out_pedal_echo,
  input logic [pac_pkg::VALUE_W-1:0]  out_conditioned_value,
  input logic [pac_pkg::AXIS_W-1:0]   out_axis_value
);

  // A transfer starts multi-cycle work, so the input side closes at once.
  `PAC_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "input taken while busy")

  // The axis value is always the top twelve bits of the conditioned value.
  `PAC_ASSERT_IMP(a_axis_match, clk, rst_n, out_valid, out_axis_value == out_conditioned_value[15:4], "axis value mismatch")

  // A pedal index beyond the configured pedals always gives a zero result.
  `PAC_ASSERT_IMP(a_bad_pedal_zero, clk, rst_n, out_valid && (32'(out_pedal_echo) >= NUM_PEDALS), out_conditioned_value == '0, "unknown pedal gave a non-zero value")

  // A stalled result holds until its transfer.
  `PAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_conditioned_value) && $stable(out_pedal_echo), "stalled result changed")

endmodule

bind pedal_axis_conditioner_unit pac_checker #(
  .NUM_PEDALS(NUM_PEDALS)
) u_pac_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_pedal_echo       (out_pedal_echo),
  .out_conditioned_value(out_conditioned_value),
  .out_axis_value       (out_axis_value)
);

[dv/pedal_axis_conditioner_unit_tb.sv]
// Self-checking testbench of the pedal axis conditioner: directed and random samples checked against a fixed-point predictor.
`timescale 1ns / 100ps

module pedal_axis_conditioner_unit_tb;

  import pac_pkg::*;

  localparam int unsigned NUM_PEDALS  = 3;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 70;
  localparam int unsigned PRINT_LIMIT = 40;
  localparam longint      UNIT_Q16    = 65536;

  // Register map, one 64-bit register every eight bytes.
  typedef enum logic [2:0] {
    REG_P0_SETUP, REG_P0_CURVE, REG_P1_SETUP, REG_P1_CURVE,
    REG_P2_SETUP, REG_P2_CURVE, REG_SPARE_A, REG_SPARE_B
  } reg_idx_e;

  typedef enum logic [PEDAL_W-1:0] {
    PEDAL_CLUTCH, PEDAL_BRAKE, PEDAL_THROTTLE, PEDAL_NONE
  } pedal_e;

  typedef struct {
    logic [PEDAL_W-1:0] pedal;
    logic [VALUE_W-1:0] value;
    logic [AXIS_W-1:0]  axis;
  } pedal_result_t;

  // Shadow of the pedal settings and smoothing levels, and the results still owed.
  class pedal_tracker;
    logic [SETUP_W-1:0] setup_q [NUM_PEDALS];
    logic [CURVE_W-1:0] curve_q [NUM_PEDALS];
    logic [LEVEL_W-1:0] level_q [NUM_PEDALS];
    pedal_result_t      owed_results [$];
    int unsigned        errors, samples, absent, results, writes;

    function new();
      for (int k = 0; k < NUM_PEDALS; k++) begin
        setup_q[k] = SETUP_RESET;
        curve_q[k] = CURVE_RESET;
        level_q[k] = '0;
      end
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function longint clamp_unit(longint v);
      if (v < 0) return 0;
      if (v > UNIT_Q16) return UNIT_Q16;
      return v;
    endfunction

    function longint curve_pt(logic [CURVE_W-1:0] cv, int unsigned j);
      return longint'(cv[8*j +: 8]);
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] data);
      int unsigned k;
      k = int'(idx) / 2;
      writes++;
      if (k >= NUM_PEDALS) return;
      if (int'(idx) % 2 == 0) setup_q[k] = data[SETUP_W-1:0];
      else curve_q[k] = data[CURVE_W-1:0];
    endfunction

    // Range, inversion, deadzone, curve, scaling and smoothing of one sample.
    function logic [VALUE_W-1:0] smoothed_output(int unsigned p, logic [SAMPLE_W-1:0] raw);
      logic [SETUP_W-1:0] su;
      logic [CURVE_W-1:0] cv;
      longint lo, hi, dz_lo, dz_hi, alpha, n, d, num, pos, frac, y, tgt, pt_a, pt_b;
      longint total, lvl, rounded;
      int unsigned seg;
      su    = setup_q[p];
      cv    = curve_q[p];
      lo    = longint'(su[11:0]);
      hi    = longint'(su[23:12]);
      dz_lo = longint'(su[40:33]);
      dz_hi = longint'(su[48:41]);
      alpha = longint'(su[32:25]);
      if (alpha > 95) alpha = 95;

      // Normalise against the calibrated range; an empty range gives zero.
      n = 0;
      if (hi > lo) begin
        d = longint'(raw) - lo;
        if (d < 0) d = 0;
        n = clamp_unit((d * UNIT_Q16) / (hi - lo));
      end
      if (su[24]) n = UNIT_Q16 - n;

      // Percent deadzone; an empty deadzone gives zero.
      if (dz_hi > dz_lo) begin
        num = n * 100 - dz_lo * UNIT_Q16;
        if (num < 0) num = 0;
        n = clamp_unit(num / (dz_hi - dz_lo));
      end else begin
        n = 0;
      end

      // Six-point curve in percent Q16, saturating at full scale.
      pos  = n * 5;
      seg  = 32'(pos / UNIT_Q16);
      frac = pos % UNIT_Q16;
      if (seg >= 5) begin
        y = curve_pt(cv, 5) * UNIT_Q16;
      end else begin
        pt_a = curve_pt(cv, seg);
        pt_b = curve_pt(cv, seg + 1);
        y = pt_a * UNIT_Q16 + (pt_b - pt_a) * frac;
      end
      if (y < 0) y = 0;
      if (y > 100 * UNIT_Q16) y = 100 * UNIT_Q16;
      tgt = (y * 65535) / 100;

      // Exponential smoothing of the Q16.16 level, rounded to nearest.
      total = longint'(level_q[p]) * alpha + tgt * (100 - alpha) + 50;
      lvl = total / 100;
      if (lvl > 64'hFFFF_FFFF) lvl = 64'hFFFF_FFFF;
      level_q[p] = lvl[31:0];
      rounded = (lvl + 32768) / UNIT_Q16;
      if (rounded > 65535) rounded = 65535;
      return rounded[15:0];
    endfunction

    function void note_sample(logic [PEDAL_W-1:0] pedal, logic [SAMPLE_W-1:0] raw);
      pedal_result_t r;
      r.pedal = pedal;
      r.value = '0;
      if (pedal < NUM_PEDALS) r.value = smoothed_output(pedal, raw);
      else absent++;
      r.axis = r.value[15:4];
      owed_results.push_back(r);
      samples++;
    endfunction

    task check_result(logic [PEDAL_W-1:0] pedal, logic [VALUE_W-1:0] value,
                      logic [AXIS_W-1:0] axis);
      pedal_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result with none owed: pedal %0d value %0d", pedal, value));
        return;
      end
      want = owed_results.pop_front();
      results++;
      if (pedal !== want.pedal)
        report($sformatf("pedal_echo %0d, wanted %0d", pedal, want.pedal));
      if (value !== want.value)
        report($sformatf("pedal %0d conditioned_value %0d, wanted %0d",
                         want.pedal, value, want.value));
      if (axis !== want.axis)
        report($sformatf("pedal %0d axis_value %0d, wanted %0d", want.pedal, axis, want.axis));
    endtask

    task check_register(reg_idx_e idx, logic [63:0] data);
      logic [63:0] want;
      int unsigned k;
      k = int'(idx) / 2;
      if (int'(idx) % 2 == 0) want = {{(64-SETUP_W){1'b0}}, setup_q[k]};
      else want = {{(64-CURVE_W){1'b0}}, curve_q[k]};
      if (data !== want) report($sformatf("%s read %h, wanted %h", idx.name(), data, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PEDAL_W-1:0] in_pedal = '0;
  logic [SAMPLE_W-1:0] in_raw_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PEDAL_W-1:0] out_pedal_echo;
  logic [VALUE_W-1:0] out_conditioned_value;
  logic [AXIS_W-1:0] out_axis_value;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned rx_hold = 0;
  pedal_tracker tracker = new();

  pedal_axis_conditioner_unit #(.NUM_PEDALS(NUM_PEDALS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pedal(in_pedal), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pedal_echo(out_pedal_echo), .out_conditioned_value(out_conditioned_value),
    .out_axis_value(out_axis_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle stretch length: mostly short, now and then long.
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [63:0] pack_setup(logic [11:0] lo, logic [11:0] hi, logic inv,
                                             logic [7:0] sm, logic [7:0] dz_lo,
                                             logic [7:0] dz_hi);
    return {15'h0, dz_hi, dz_lo, sm, inv, hi, lo};
  endfunction

  function automatic logic [63:0] pack_curve(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                             logic [7:0] p3, logic [7:0] p4, logic [7:0] p5);
    return {16'h0, p5, p4, p3, p2, p1, p0};
  endfunction

  // Mostly plausible calibrations, with empty ranges, empty deadzones and raw noise.
  function automatic logic [63:0] random_setup();
    logic [11:0] lo, hi;
    logic [7:0] sm, dz_lo, dz_hi;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return {$urandom, $urandom};
    lo    = 12'($urandom_range(0, 1500));
    hi    = 12'((r == 1) ? $urandom_range(0, lo) : $urandom_range(2500, 4095));
    sm    = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60));
    dz_lo = 8'($urandom_range(0, 25));
    dz_hi = 8'((r == 2) ? $urandom_range(0, dz_lo) : $urandom_range(75, 110));
    return pack_setup(lo, hi, 1'($urandom_range(0, 1)), sm, dz_lo, dz_hi);
  endfunction

  // Mostly rising curves, some passing 100 percent, now and then raw noise.
  function automatic logic [63:0] random_curve();
    logic [7:0] pt [6];
    int unsigned acc;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    acc = $urandom_range(0, 20);
    for (int j = 0; j < 6; j++) begin
      pt[j] = (acc > 255) ? 8'hFF : acc[7:0];
      acc += $urandom_range(0, 30);
    end
    return pack_curve(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5]);
  endfunction

  // Register write: setup phase, access phase, then the bus returns to idle.
  task automatic apb_write(input reg_idx_e idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input reg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.check_register(idx, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_regs();
    for (int k = 0; k < 2 * NUM_PEDALS; k++) apb_read(reg_idx_e'(k));
  endtask

  task automatic load_pedal(input int unsigned k, input logic [63:0] setup,
                            input logic [63:0] curve);
    apb_write(reg_idx_e'(2 * k), setup);
    apb_write(reg_idx_e'(2 * k + 1), curve);
  endtask

  // Holds the sender back until every owed result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offers one sample after an optional gap; returns at the edge of its transfer.
  task automatic send_sample(input pedal_e p, input logic [SAMPLE_W-1:0] raw);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : gap_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pedal      <= p;
    in_raw_sample <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (rx_steady || $urandom_range(0, 99) < 60) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_hold   <= gap_length() - 1;
    end
  end

  // Every transfer on either channel goes to the tracker.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.note_sample(in_pedal, in_raw_sample);
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_pedal_echo, out_conditioned_value, out_axis_value);
  end

  // Watchdog: ends the run after a long stretch without any transfer or write.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned settings, r;
    pedal_e p;
    logic [SAMPLE_W-1:0] raw;
    settings = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: rails, mid-scale and the pedal index with no pedal behind it.
    verify_regs();
    send_sample(PEDAL_CLUTCH, 12'h000);
    send_sample(PEDAL_CLUTCH, 12'hFFF);
    send_sample(PEDAL_BRAKE, 12'h800);
    send_sample(PEDAL_THROTTLE, 12'hFFF);
    send_sample(PEDAL_NONE, 12'hFFF);
    send_sample(PEDAL_NONE, 12'h000);
    drain();

    // Inverted narrow range with saturated smoothing and a falling curve; an empty
    // range on a curve far above 100 percent; an empty deadzone; writes to spare slots.
    load_pedal(PEDAL_CLUTCH, pack_setup(12'd1000, 12'd3000, 1'b1, 8'd255, 8'd10, 8'd90),
               pack_curve(8'd100, 8'd80, 8'd60, 8'd40, 8'd20, 8'd0));
    load_pedal(PEDAL_BRAKE, pack_setup(12'd3000, 12'd1000, 1'b0, 8'd0, 8'd0, 8'd100),
               pack_curve(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    load_pedal(PEDAL_THROTTLE, pack_setup(12'd0, 12'd4095, 1'b0, 8'd50, 8'd60, 8'd40),
               {16'h0, CURVE_RESET});
    apb_write(REG_SPARE_A, '1);
    apb_write(REG_SPARE_B, 64'h0123_4567_89AB_CDEF);
    verify_regs();
    settings++;
    send_sample(PEDAL_CLUTCH, 12'h000);
    send_sample(PEDAL_CLUTCH, 12'hFFF);
    send_sample(PEDAL_CLUTCH, 12'd2000);
    send_sample(PEDAL_CLUTCH, 12'd3000);
    send_sample(PEDAL_BRAKE, 12'hFFF);
    send_sample(PEDAL_THROTTLE, 12'hFFF);
    send_sample(PEDAL_THROTTLE, 12'h000);
    drain();

    // Every bit set, including bits beyond the register widths.
    for (int k = 0; k < NUM_PEDALS; k++) load_pedal(k, '1, '1);
    verify_regs();
    settings++;
    send_sample(PEDAL_CLUTCH, 12'hFFF);
    send_sample(PEDAL_BRAKE, 12'h000);
    send_sample(PEDAL_THROTTLE, 12'h800);
    drain();

    // Every bit clear.
    for (int k = 0; k < NUM_PEDALS; k++) load_pedal(k, '0, '0);
    verify_regs();
    settings++;
    send_sample(PEDAL_CLUTCH, 12'd1234);
    send_sample(PEDAL_THROTTLE, 12'hFFF);

    // Random phases, each with fresh settings and its own idling pattern.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      tx_steady = (ph % 3 == 1);
      rx_steady <= (ph % 4 == 2);
      for (int k = 0; k < NUM_PEDALS; k++) load_pedal(k, random_setup(), random_curve());
      if (ph % 3 == 0) apb_write(REG_SPARE_B, {$urandom, $urandom});
      verify_regs();
      settings++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(0, 99);
        p = (r < 4) ? PEDAL_NONE : pedal_e'($urandom_range(0, NUM_PEDALS - 1));
        r = $urandom_range(0, 99);
        if (r < 5) raw = '0;
        else if (r < 10) raw = '1;
        else raw = 12'($urandom_range(0, 4095));
        send_sample(p, raw);
      end
    end

    // Let the last results out and watch for any stray one.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples (%0d for the absent pedal) over %0d settings and %0d writes.",
             tracker.samples, tracker.absent, settings, tracker.writes);
    $display("Checked %0d results; %0d mismatches.", tracker.results, tracker.errors);
    if (tracker.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/pac_pkg.sv
sv/pac_regs.sv
sv/pac_div.sv
sv/pac_core.sv
sv/pedal_axis_conditioner_unit.sv
sv/pac_checker.sv
dv/pedal_axis_conditioner_unit_tb.sv
